// ===== rtl/ttc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared widths, register map and helpers for the touch tap classifier.
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int TIME_BITS = 12;
  localparam int REG_W     = 12;
  localparam int CMP_W     = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  typedef logic [TIME_BITS-1:0] age_t;
  typedef logic [REG_W-1:0]     reg_val_t;
  typedef logic [CMP_W-1:0]     cmp_t;

  typedef enum logic [1:0] {
    REG_MIN_PRESS  = 2'd0,
    REG_MAX_PRESS  = 2'd1,
    REG_DBL_WINDOW = 2'd2,
    REG_MIN_GAP    = 2'd3
  } reg_idx_t;

  localparam reg_val_t RST_MIN_PRESS  = reg_val_t'(20);
  localparam reg_val_t RST_MAX_PRESS  = reg_val_t'(500);
  localparam reg_val_t RST_DBL_WINDOW = reg_val_t'(400);
  localparam reg_val_t RST_MIN_GAP    = reg_val_t'(50);

  localparam age_t AGE_MAX = {TIME_BITS{1'b1}};

  function automatic age_t age_inc(input age_t a);
    age_inc = (a == AGE_MAX) ? AGE_MAX : a + age_t'(1);
  endfunction

  function automatic cmp_t age_ext(input age_t a);
    age_ext = cmp_t'(a);
  endfunction

  function automatic cmp_t reg_ext(input reg_val_t r);
    reg_ext = cmp_t'(r);
  endfunction

endpackage

// ===== rtl/touch_tap_classifier.sv =====
// ----------------------------------------------------------------------------
// touch_tap_classifier
// Classifies touch-pad level samples into single and double taps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one touch_level sample per beat (in_valid / in_stall).
//   Output channel: one result beat per input beat carrying single_tap and
//   double_tap (out_valid / out_stall).
//   A sample accepted at an edge gives its result on out_* right after that
//   edge. Throughput is one sample per cycle while out_stall is low, set by
//   the single result register behind the tap state update.
//   While a result waits under out_stall, in_stall is raised; a new sample
//   is taken in the same cycle that the waiting result is taken.
//   Thresholds are set through the cfg_ APB port (addresses 0, 4, 8, 12); the
//   user must write them only while the block is idle (not enforced here).
//   Reset (rst_n low, synchronous) restores the default thresholds, clears
//   the pad and pending tap state and empties the result register.
// ----------------------------------------------------------------------------
module touch_tap_classifier
  import ttc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_touch_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_single_tap,
  output logic              out_double_tap,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  reg_val_t min_press_r, max_press_r, dbl_window_r, min_gap_r;
  logic     pad_pressed_r, pad_pressed_nxt;
  age_t     press_age_r, press_age_nxt;
  logic     tap_pending_r, tap_pending_nxt;
  age_t     tap_age_r, tap_age_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     single_r, single_nxt;
  logic     double_r, double_nxt;

  logic     in_acc, out_acc, cfg_wr;
  reg_idx_t cfg_idx;
  age_t     press_aged, tap_aged;
  logic     expire, is_tap, gap_ok;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_MIN_PRESS:  cfg_prdata = DATA_W'(min_press_r);
      REG_MAX_PRESS:  cfg_prdata = DATA_W'(max_press_r);
      REG_DBL_WINDOW: cfg_prdata = DATA_W'(dbl_window_r);
      REG_MIN_GAP:    cfg_prdata = DATA_W'(min_gap_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_press_r  <= RST_MIN_PRESS;
      max_press_r  <= RST_MAX_PRESS;
      dbl_window_r <= RST_DBL_WINDOW;
      min_gap_r    <= RST_MIN_GAP;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MIN_PRESS:  min_press_r  <= cfg_pwdata[REG_W-1:0];
        REG_MAX_PRESS:  max_press_r  <= cfg_pwdata[REG_W-1:0];
        REG_DBL_WINDOW: dbl_window_r <= cfg_pwdata[REG_W-1:0];
        REG_MIN_GAP:    min_gap_r    <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_acc  = out_valid_r && !out_stall;
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    press_aged = pad_pressed_r ? age_inc(press_age_r) : press_age_r;
    tap_aged   = tap_pending_r ? age_inc(tap_age_r) : tap_age_r;
    expire     = tap_pending_r && (age_ext(tap_aged) >= reg_ext(dbl_window_r));
    is_tap     = (age_ext(press_aged) >= reg_ext(min_press_r)) &&
                 (age_ext(press_aged) <= reg_ext(max_press_r));
    gap_ok     = (age_ext(tap_aged) > reg_ext(min_gap_r)) &&
                 (age_ext(tap_aged) < reg_ext(dbl_window_r));

    pad_pressed_nxt = pad_pressed_r;
    press_age_nxt   = press_aged;
    tap_pending_nxt = tap_pending_r && !expire;
    tap_age_nxt     = expire ? '0 : tap_aged;
    single_nxt      = expire;
    double_nxt      = 1'b0;

    if (in_touch_level && !pad_pressed_r) begin
      pad_pressed_nxt = 1'b1;
      press_age_nxt   = '0;
    end else if (!in_touch_level && pad_pressed_r) begin
      pad_pressed_nxt = 1'b0;
      if (is_tap) begin
        if (tap_pending_nxt && gap_ok) begin
          double_nxt      = 1'b1;
          tap_pending_nxt = 1'b0;
        end else begin
          tap_pending_nxt = 1'b1;
        end
        tap_age_nxt = '0;
      end
    end

    out_valid_nxt = in_acc || (out_valid_r && !out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_pressed_r <= 1'b0;
      press_age_r   <= '0;
      tap_pending_r <= 1'b0;
      tap_age_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        pad_pressed_r <= pad_pressed_nxt;
        press_age_r   <= press_age_nxt;
        tap_pending_r <= tap_pending_nxt;
        tap_age_r     <= tap_age_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      single_r <= single_nxt;
      double_r <= double_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_single_tap = single_r;
  assign out_double_tap = double_r;

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(single_r && double_r))
    else $error("single and double tap in one result");

  a_dbl_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && double_nxt |=> !tap_pending_r && tap_age_r == '0 && double_r)
    else $error("double tap left a pending tap");

  a_press_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_touch_level && !pad_pressed_r |=> pad_pressed_r && press_age_r == '0)
    else $error("press start not recorded");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(single_r) && $stable(double_r))
    else $error("stalled result lost");

endmodule

// ===== tb/touch_tap_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// touch_tap_classifier_tb
// Drives touch-pad level samples into the tap classifier under random idle and
// stall on both channels. A scoreboard tracks press and pending-tap timing to
// predict each single/double tap result beat. The run covers several threshold
// settings: the reset values, small windows, an inverted and so empty press range,
// a zero window, and the largest thresholds with upper data bits set.
// ----------------------------------------------------------------------------
module touch_tap_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttc_pkg::*;

  typedef struct packed {
    logic single_tap;
    logic double_tap;
  } tap_flags_t;

  class tap_scoreboard;
    reg_val_t   min_press;
    reg_val_t   max_press;
    reg_val_t   dbl_window;
    reg_val_t   min_gap;
    logic       pressed;
    logic       pending;
    age_t       press_age;
    age_t       tap_age;
    tap_flags_t taps_due[$];
    int         errors;

    function new();
      min_press  = RST_MIN_PRESS;
      max_press  = RST_MAX_PRESS;
      dbl_window = RST_DBL_WINDOW;
      min_gap    = RST_MIN_GAP;
      pressed    = 1'b0;
      pending    = 1'b0;
      press_age  = '0;
      tap_age    = '0;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
      reg_val_t v;
      v = value[REG_W-1:0];
      case (idx)
        REG_MIN_PRESS:  min_press  = v;
        REG_MAX_PRESS:  max_press  = v;
        REG_DBL_WINDOW: dbl_window = v;
        REG_MIN_GAP:    min_gap    = v;
        default: ;
      endcase
    endfunction

    function void note_sample(logic level);
      tap_flags_t res;
      res = '0;
      if (pressed && press_age != AGE_MAX) press_age = press_age + 1'b1;
      if (pending && tap_age != AGE_MAX) tap_age = tap_age + 1'b1;
      if (pending && tap_age >= dbl_window) begin
        res.single_tap = 1'b1;
        pending        = 1'b0;
        tap_age        = '0;
      end
      if (level && !pressed) begin
        pressed   = 1'b1;
        press_age = '0;
      end else if (!level && pressed) begin
        pressed = 1'b0;
        if (press_age >= min_press && press_age <= max_press) begin
          if (pending && tap_age > min_gap && tap_age < dbl_window) begin
            res.double_tap = 1'b1;
            pending        = 1'b0;
            tap_age        = '0;
          end else begin
            pending = 1'b1;
            tap_age = '0;
          end
        end
      end
      taps_due.push_back(res);
    endfunction

    function void check_taps(logic single_tap, logic double_tap);
      tap_flags_t want;
      if (taps_due.size() == 0) begin
        $error("unexpected result beat: single_tap=%0b double_tap=%0b",
               single_tap, double_tap);
        errors++;
        return;
      end
      want = taps_due.pop_front();
      if (single_tap !== want.single_tap) begin
        $error("single_tap: expected %0b, got %0b", want.single_tap, single_tap);
        errors++;
      end
      if (double_tap !== want.double_tap) begin
        $error("double_tap: expected %0b, got %0b", want.double_tap, double_tap);
        errors++;
      end
    endfunction

    function int waiting();
      return taps_due.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              in_touch_level = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              out_single_tap;
  logic              out_double_tap;
  logic              cfg_psel       = 1'b0;
  logic              cfg_penable    = 1'b0;
  logic              cfg_pwrite     = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr      = '0;
  logic [DATA_W-1:0] cfg_pwdata     = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  tap_scoreboard sb;
  bit            tx_idle = 1'b1;
  bit            rx_idle = 1'b1;
  int            sent_items = 0;

  touch_tap_classifier dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_touch_level (in_touch_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_single_tap (out_single_tap),
    .out_double_tap (out_double_tap),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_touch_level);
      if (out_valid && !out_stall) sb.check_taps(out_single_tap, out_double_tap);
    end
  end

  initial begin
    int n;
    forever begin
      n = rx_idle ? $urandom_range(0, 13) : 0;
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_level(input logic lvl);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_touch_level <= lvl;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic send_run(input logic lvl, input int count);
    repeat (count) send_level(lvl);
  endtask

  // drop valid and hold until every predicted beat has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] word);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, word);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_thresholds(input int mn, input int mx, input int win, input int gap,
                                input bit ones_above);
    int          vals[4];
    logic [19:0] upper;
    vals = '{mn, mx, win, gap};
    for (int i = 0; i < 4; i++) begin
      upper = ones_above ? '1 : 20'($urandom);
      cfg_write(reg_idx_t'(i), {upper, reg_val_t'(vals[i])});
    end
  endtask

  function automatic int pick_len(input int lo, input int hi);
    int v;
    case ($urandom_range(0, 6))
      0: v = lo - 1;
      1: v = lo;
      2: v = lo + 1;
      3: v = hi - 1;
      4: v = hi;
      5: v = hi + 1;
      default: v = $urandom_range(1, hi + 2);
    endcase
    if (v < 1) v = 1;
    if (v > 64) v = $urandom_range(1, 64);
    return v;
  endfunction

  task automatic run_random(input int budget, input bit pause_mid);
    int start;
    int hold;
    int z;
    bit paused;
    start  = sent_items;
    paused = 1'b0;
    while (sent_items - start < budget) begin
      if (pause_mid && !paused && sent_items - start >= budget / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) begin
        hold = pick_len(int'(sb.min_press), int'(sb.max_press));
        z    = pick_len(int'(sb.min_gap), int'(sb.dbl_window)) - int'(sb.min_press);
        if (z < 1) z = 1;
        send_run(1'b1, hold);
        send_run(1'b0, z);
      end else begin
        repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset thresholds
    run_random(100, 1'b0);
    drain();

    // directed: short press, expiry, max press, double tap, gap at min,
    // expiry on the same tick as a new tap, press over max
    set_thresholds(2, 3, 6, 3, 1'b0);
    send_run(1'b1, 1); send_run(1'b0, 1);
    send_run(1'b1, 2); send_run(1'b0, 6);
    send_run(1'b1, 3); send_run(1'b0, 2);
    send_run(1'b1, 2); send_run(1'b0, 1);
    send_run(1'b1, 2); send_run(1'b0, 1);
    send_run(1'b1, 2); send_run(1'b0, 4);
    send_run(1'b1, 2); send_run(1'b0, 2);
    send_run(1'b1, 4); send_run(1'b0, 1);
    run_random(200, 1'b1);
    drain();

    tx_idle = 1'b0;
    rx_idle = 1'b1;
    set_thresholds(1, 3, 4, 1, 1'b0);
    run_random(200, 1'b0);
    drain();

    // every press a tap, zero window
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    set_thresholds(0, 4095, 0, 0, 1'b0);
    run_random(150, 1'b0);
    drain();

    // inverted press range
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_thresholds(7, 3, 6, 2, 1'b0);
    run_random(100, 1'b0);
    drain();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_thresholds(3, 8, 12, 10, 1'b0);
    run_random(150, 1'b0);
    drain();

    repeat (2) begin
      tx_idle = 1'($urandom_range(0, 1));
      rx_idle = 1'($urandom_range(0, 1));
      begin
        int mn;
        int win;
        mn  = $urandom_range(0, 6);
        win = $urandom_range(0, 16);
        set_thresholds(mn, mn + $urandom_range(0, 8), win, $urandom_range(0, win), 1'b0);
      end
      run_random(100, 1'b0);
      drain();
    end

    // largest thresholds, upper data bits set
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_thresholds(4095, 4095, 4095, 4095, 1'b1);
    send_run(1'b1, 30);
    send_run(1'b0, 30);
    drain();

    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
